// File: rtl/rsort_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsort_pkg: shared types and constants of the record insertion sorter
// Record layout, sort key codes, back-end states and the key helper.
// ---------------------------------------------------------------------------
package rsort_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int TAG_W       = 10;
	localparam int KEY_W       = 16;
	localparam int REC_W       = TAG_W + 2 * KEY_W;
	localparam int TDATA_W     = ((REC_W + 7) / 8) * 8;

	// Configuration register addresses (word index).
	localparam logic REG_SORT_KEY = 1'b0;

	// Raw codes of the sort_key register.
	localparam logic [1:0] SORT_CODE_QUALITY    = 2'd1;
	localparam logic [1:0] SORT_CODE_DIFFICULTY = 2'd2;
	localparam logic [1:0] SORT_KEY_RESET       = SORT_CODE_QUALITY;

	typedef enum logic [1:0] {
		KEY_NONE,
		KEY_QUALITY,
		KEY_DIFFICULTY
	} key_sel_t;

	// First member sits in the upper bits, so the tag lands in bits 9:0.
	typedef struct packed {
		logic [KEY_W-1:0] difficulty;
		logic [KEY_W-1:0] quality;
		logic [TAG_W-1:0] tag;
	} rec_t;

	typedef struct packed {
		rec_t     rec;
		logic     last;
		key_sel_t key;
	} q_entry_t;

	typedef struct packed {
		logic             emitting;
		logic [CNT_W-1:0] count;
	} back_status_t;

	typedef enum logic [2:0] {
		B_LOAD,
		B_RD_I,
		B_LD_I,
		B_CMP,
		B_PUT,
		B_E_RD,
		B_E_OUT
	} back_state_t;

	// Sort key of a record under the chosen selection.
	function automatic logic [KEY_W-1:0] key_of(input rec_t r, input key_sel_t sel);
		logic [KEY_W-1:0] k;
		begin
			case (sel)
				KEY_QUALITY:    k = r.quality;
				KEY_DIFFICULTY: k = r.difficulty;
				default:        k = '0;
			endcase
			return k;
		end
	endfunction

endpackage

// File: rtl/rsort_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsort_front: input beat acceptance and record queue
// Classifies each beat with the current sort key and queues it for the back.
// ---------------------------------------------------------------------------
module rsort_front import rsort_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // tag, quality, difficulty, zero pad
	input  logic               s_axis_tlast,
	input  logic [1:0]         sort_key,
	output logic               q_valid,
	output q_entry_t           q_head,
	input  logic               q_pop,
	output logic [QCNT_W-1:0]  q_fill
);

	q_entry_t            fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                push;
	logic                pop;
	q_entry_t            entry;
	key_sel_t            key_class;

	// Classify the key code at acceptance; the unused codes keep load order.
	always_comb begin
		case (sort_key)
			SORT_CODE_QUALITY:    key_class = KEY_QUALITY;
			SORT_CODE_DIFFICULTY: key_class = KEY_DIFFICULTY;
			default:              key_class = KEY_NONE;
		endcase
	end

	assign entry.rec  = rec_t'(s_axis_tdata[REC_W-1:0]);
	assign entry.last = s_axis_tlast;
	assign entry.key  = key_class;

	assign s_axis_tready = (fill_q != QCNT_W'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (fill_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_head        = fifo_q[rd_ptr_q];
	assign q_fill        = fill_q;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QCNT_W'(1);
				2'b01:   fill_q <= fill_q - QCNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/rsort_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsort_back: record store, insertion sort sequencer and output register
// Stores records in load order, sorts the batch in place unless no key is set, then emits it.
// ---------------------------------------------------------------------------
module rsort_back import rsort_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  q_entry_t           q_head,
	output logic               q_pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // tag, quality, difficulty, zero pad
	output logic               m_axis_tlast,
	output logic               m_axis_tuser, // overflowed
	output back_status_t       status
);

	rec_t             mem [MAX_RECORDS];
	rec_t             rdata_q;
	back_state_t      state_q;
	back_state_t      state_d;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	key_sel_t         key_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	rec_t             tmp_q;
	logic             out_valid_q;
	rec_t             out_rec_q;
	logic             out_last_q;
	logic             out_ovf_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	rec_t             wdata;
	logic [IDX_W-1:0] raddr;
	logic             room;
	logic [CNT_W-1:0] n_after;
	logic             less;
	logic             i_more;
	logic             k_last;
	logic             out_load;

	assign room     = (count_q < CNT_W'(MAX_RECORDS));
	assign n_after  = room ? count_q + CNT_W'(1) : count_q;
	assign less     = key_of(tmp_q, key_q) < key_of(rdata_q, key_q);
	assign i_more   = (CNT_W'(i_q) + CNT_W'(1)) < count_q;
	assign k_last   = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
	assign out_load = (state_q == B_E_OUT) && (!out_valid_q || m_axis_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_LOAD: begin
				if (q_valid && q_head.last) begin
					if (q_head.key != KEY_NONE && n_after >= CNT_W'(2)) begin
						state_d = B_RD_I;
					end else begin
						state_d = B_E_RD;
					end
				end
			end
			B_RD_I: state_d = B_LD_I;
			B_LD_I: state_d = B_CMP;
			B_CMP: begin
				if (less) begin
					if (j_q == IDX_W'(1)) begin
						state_d = B_PUT;
					end
				end else begin
					state_d = i_more ? B_RD_I : B_E_RD;
				end
			end
			B_PUT:  state_d = i_more ? B_RD_I : B_E_RD;
			B_E_RD: state_d = B_E_OUT;
			B_E_OUT: begin
				if (out_load) begin
					state_d = k_last ? B_LOAD : B_E_RD;
				end
			end
			default: state_d = B_LOAD;
		endcase
	end

	// Store port controls for each state.
	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = tmp_q;
		raddr = k_q;
		q_pop = 1'b0;
		case (state_q)
			B_LOAD: begin
				q_pop = q_valid;
				we    = q_valid && room;
				waddr = count_q[IDX_W-1:0];
				wdata = q_head.rec;
			end
			B_RD_I: raddr = i_q;
			B_LD_I: raddr = i_q - IDX_W'(1);
			B_CMP: begin
				we    = 1'b1;
				wdata = less ? rdata_q : tmp_q;
				raddr = j_q - IDX_W'(2);
			end
			B_PUT:   we = 1'b1;
			B_E_RD:  raddr = k_q;
			B_E_OUT: raddr = k_q;
			default: raddr = k_q;
		endcase
	end

	// Record store with a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Sort working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			B_LD_I: begin
				tmp_q <= rdata_q;
				j_q   <= i_q;
			end
			B_CMP: begin
				if (less) begin
					j_q <= j_q - IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, batch bookkeeping and loop indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			key_q   <= KEY_NONE;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_LOAD: begin
					if (q_valid) begin
						count_q <= n_after;
						if (!room) begin
							drop_q <= 1'b1;
						end
						key_q <= q_head.key;
						i_q   <= IDX_W'(1);
						k_q   <= '0;
					end
				end
				B_CMP: begin
					if (!less) begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				B_PUT: i_q <= i_q + IDX_W'(1);
				B_E_OUT: begin
					if (out_load) begin
						k_q <= k_q + IDX_W'(1);
						if (k_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: holds one result beat while the next is fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rec_q  <= rdata_q;
			out_last_q <= k_last;
			out_ovf_q  <= drop_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = TDATA_W'(out_rec_q);
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser    = out_ovf_q;
	assign status.emitting = (state_q == B_E_OUT);
	assign status.count    = count_q;

endmodule

// File: rtl/record_insertion_sorter.sv
`timescale 1ns / 1ps
// A record enters the queue and is written to the store while heading it in the load state.
// After the final beat the batch is sorted in the store, which reads and writes at once:
// each record is read, loaded and compared, one compare step per shifted entry; emission
// reads each result beat and then loads it. Loading runs at one beat per cycle in the load
// state, else the four-entry queue fills. Reset clears the queue, counters and drop flag,
// sets sort_key to quality and leaves the store undefined; it needs no clearing pass.
// ---------------------------------------------------------------------------
// record_insertion_sorter: batch sorter for tagged records
// Loads records, sorts each batch stably on a selectable key (an unused code keeps load order) and streams it out.
// ---------------------------------------------------------------------------
module record_insertion_sorter import rsort_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // record_tag, quality_key, difficulty_key, pad
	input  logic               s_axis_tlast,  // final_record
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // out_tag, out_quality, out_difficulty, pad
	output logic               m_axis_tlast,  // end_of_batch
	output logic               m_axis_tuser   // overflowed
);

	logic [1:0]        sort_key_q;
	logic              q_valid;
	q_entry_t          q_head;
	logic              q_pop;
	logic [QCNT_W-1:0] q_fill;
	back_status_t      status;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q <= SORT_KEY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SORT_KEY) begin
			sort_key_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SORT_KEY) ? {30'd0, sort_key_q} : 32'd0;

	rsort_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.sort_key      (sort_key_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.q_fill        (q_fill)
	);

	rsort_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.status        (status)
	);

	// The stored record count never passes the store capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond capacity");

	// The queue never holds more entries than it has.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= QCNT_W'(QDEPTH))
		else $error("queue fill beyond depth");

	// A result beat only appears after the sequencer was in its emit step.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(status.emitting))
		else $error("result beat outside emit phase");

	// The queue is never popped while the back is emitting a batch.
	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		status.emitting |-> !q_pop)
		else $error("queue popped during emission");

endmodule
